// ===== design/tbsd_pkg.sv =====
// Shared types and constants of the tagged block stream deframer.
package tbsd_pkg;

	localparam int NUM_BLOCKS_DEF = 16;

	localparam logic [7:0]  MAGIC_P       = 8'h50;
	localparam logic [7:0]  MAGIC_S       = 8'h53;
	localparam logic [31:0] LONGEST_RESET = 32'd4096;

	localparam logic REQ_STREAM = 1'b0;
	localparam logic REQ_SETUP  = 1'b1;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_EMPTY = 2'd1,
		KIND_ERROR = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  rx_byte;
		logic [3:0]  block_sel;
		logic [31:0] max_len;
	} in_item_t;

	typedef struct packed {
		out_kind_t   out_kind;
		logic [3:0]  block_id;
		logic [31:0] byte_offset;
		logic [7:0]  data_byte;
		logic [31:0] block_len;
		logic        last;
	} out_item_t;

endpackage

// ===== design/tbsd_limit_table.sv =====
// Per-block maximum length memory with a clearing pass after reset.
module tbsd_limit_table #(
	parameter int NUM_BLOCKS = tbsd_pkg::NUM_BLOCKS_DEF,
	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	output logic          clearing
);
	import tbsd_pkg::*;

	localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

	logic [31:0]   mem [NUM_BLOCKS];
	logic [31:0]   rd_data_q;
	logic [AW-1:0] clr_idx_q;
	logic          clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == LAST_IDX) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !wr_en && !rd_en)
		else $error("table accessed during clearing pass");

	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q && clr_idx_q == LAST_IDX |=> !clearing_q)
		else $error("clearing pass did not end after the last entry");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing_q |=> !clearing_q)
		else $error("clearing pass restarted without reset");

endmodule

// ===== design/tagged_block_stream_deframer.sv =====
// Top level: header parser, payload clipping and a two-entry output buffer.
// A result is registered into the output slot, or into the skid slot if that slot is held.
// Throughput: one item per cycle; in_ready falls when both slots are full or while clearing.
// The limit table read is issued once the block id is complete, ahead of the length.
// Reset initialises the control state and runs a table clearing pass over all NUM_BLOCKS
// entries, during which in_ready is low; configuration writes are taken at any time.
module tagged_block_stream_deframer #(
	parameter int NUM_BLOCKS = tbsd_pkg::NUM_BLOCKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tbsd_pkg::in_item_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tbsd_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import tbsd_pkg::*;

	localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam logic [16:0] NB_WIDE = 17'(NUM_BLOCKS);

	localparam logic [2:0] HDR_S      = 3'd1;
	localparam logic [2:0] HDR_ID_HI  = 3'd2;
	localparam logic [2:0] HDR_ID_LO  = 3'd3;
	localparam logic [2:0] HDR_LEN_HI = 3'd4;
	localparam logic [2:0] HDR_LAST   = 3'd7;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_SKIP    = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  hdr_idx_q, hdr_idx_d;
	logic [15:0] frame_id_q, frame_id_d;
	logic [31:0] frame_len_q, frame_len_d;
	logic [31:0] stored_cnt_q, stored_cnt_d;
	logic [31:0] skip_rem_q, skip_rem_d;
	logic [31:0] longest_q;
	logic [31:0] lim_q;
	logic        lim_pend_s1;

	out_item_t   out_q, skid_q, res;
	logic        out_v_q, skid_v_q, res_v;

	logic        clearing, in_acc, stream_acc, setup_acc, pop;
	logic        sel_ok, id_ok, rejected, is_last;
	logic [31:0] full_len, keep, excess, skip_dec;
	logic [15:0] id_shift;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [31:0] rd_data;
	logic        rd_en, wr_en;

	assign cfg_ready  = 1'b1;
	assign in_ready   = !skid_v_q && !clearing;
	assign in_acc     = in_valid && in_ready;
	assign stream_acc = in_acc && (in_data.req_type == REQ_STREAM);
	assign setup_acc  = in_acc && (in_data.req_type == REQ_SETUP);
	assign pop        = out_v_q && out_ready;

	assign sel_ok  = {13'd0, in_data.block_sel} < NB_WIDE;
	assign wr_en   = setup_acc && sel_ok;
	assign wr_addr = AW'({12'd0, in_data.block_sel});
	assign id_ok   = {1'b0, frame_id_q} < NB_WIDE;

	assign id_shift = {frame_id_q[7:0], in_data.rx_byte};
	assign rd_addr  = id_shift[AW-1:0];

	tbsd_limit_table #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (in_data.max_len),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clearing (clearing)
	);

	always_comb begin
		full_len = {frame_len_q[23:0], in_data.rx_byte};
		keep     = (full_len < lim_q) ? full_len : lim_q;
		excess   = full_len - keep;
		rejected = !id_ok || (full_len > longest_q);
		is_last  = (33'(stored_cnt_q) + 33'd1) >= 33'(frame_len_q);
		skip_dec = (skip_rem_q != 32'd0) ? skip_rem_q - 32'd1 : 32'd0;
	end

	always_comb begin
		phase_d      = phase_q;
		hdr_idx_d    = hdr_idx_q;
		frame_id_d   = frame_id_q;
		frame_len_d  = frame_len_q;
		stored_cnt_d = stored_cnt_q;
		skip_rem_d   = skip_rem_q;
		rd_en        = 1'b0;
		res_v        = 1'b0;
		res          = '0;
		if (stream_acc) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_idx_q == HDR_S && in_data.rx_byte != MAGIC_S) begin
						phase_d      = PH_HUNT;
						hdr_idx_d    = '0;
						res_v        = 1'b1;
						res.out_kind = KIND_ERROR;
					end else begin
						if (hdr_idx_q == HDR_ID_HI || hdr_idx_q == HDR_ID_LO) begin
							frame_id_d = id_shift;
						end else if (hdr_idx_q >= HDR_LEN_HI) begin
							frame_len_d = full_len;
						end
						rd_en     = (hdr_idx_q == HDR_ID_LO);
						hdr_idx_d = hdr_idx_q + 3'd1;
						if (hdr_idx_q == HDR_LAST) begin
							stored_cnt_d = '0;
							if (rejected) begin
								skip_rem_d = full_len;
								phase_d    = (full_len != 32'd0) ? PH_SKIP : PH_HUNT;
							end else begin
								skip_rem_d  = excess;
								frame_len_d = keep;
								if (keep == 32'd0) begin
									phase_d      = (excess != 32'd0) ? PH_SKIP : PH_HUNT;
									res_v        = 1'b1;
									res.out_kind = KIND_EMPTY;
									res.block_id = frame_id_q[3:0];
									res.last     = 1'b1;
								end else begin
									phase_d = PH_PAYLOAD;
								end
							end
						end
					end
				end
				PH_PAYLOAD: begin
					res_v           = 1'b1;
					res.out_kind    = KIND_BYTE;
					res.block_id    = frame_id_q[3:0];
					res.byte_offset = stored_cnt_q;
					res.data_byte   = in_data.rx_byte;
					res.block_len   = frame_len_q;
					res.last        = is_last;
					stored_cnt_d    = stored_cnt_q + 32'd1;
					if (is_last) begin
						phase_d = (skip_rem_q != 32'd0) ? PH_SKIP : PH_HUNT;
					end
				end
				PH_SKIP: begin
					skip_rem_d = skip_dec;
					if (skip_dec == 32'd0) begin
						phase_d = PH_HUNT;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (in_data.rx_byte == MAGIC_P) begin
						phase_d     = PH_HEADER;
						hdr_idx_d   = HDR_S;
						frame_id_d  = '0;
						frame_len_d = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			hdr_idx_q    <= '0;
			frame_id_q   <= '0;
			frame_len_q  <= '0;
			stored_cnt_q <= '0;
			skip_rem_q   <= '0;
			longest_q    <= LONGEST_RESET;
			lim_pend_s1  <= 1'b0;
			out_v_q      <= 1'b0;
			skid_v_q     <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			hdr_idx_q    <= hdr_idx_d;
			frame_id_q   <= frame_id_d;
			frame_len_q  <= frame_len_d;
			stored_cnt_q <= stored_cnt_d;
			skip_rem_q   <= skip_rem_d;
			lim_pend_s1  <= rd_en;
			if (cfg_valid && cfg_ready) begin
				longest_q <= cfg_data;
			end
			if (skid_v_q && pop) begin
				skid_v_q <= 1'b0;
			end else if (res_v) begin
				if (!out_v_q || pop) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// A set-up write to the looked-up id after the read was issued must win
	// over the memory data, so the write is forwarded into the limit.
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == frame_id_q[AW-1:0]) begin
			lim_q <= in_data.max_len;
		end else if (lim_pend_s1) begin
			lim_q <= rd_data;
		end
		if (skid_v_q && pop) begin
			out_q <= skid_q;
		end else if (res_v) begin
			if (!out_v_q || pop) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid slot holds a transaction while the output slot is empty");

	a_payload_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> stored_cnt_q < frame_len_q)
		else $error("payload offset reached the stored length");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_rem_q != 32'd0)
		else $error("skip phase with nothing left to skip");

	a_lookup_timing: assert property (@(posedge clk) disable iff (!arst_n)
		lim_pend_s1 |-> phase_q == PH_HEADER && hdr_idx_q == HDR_LEN_HI)
		else $error("limit read returned outside the length bytes of a header");

endmodule
